// ===== design/sre_pkg.sv =====
// Shared types, constants and helper functions for the sixel run-length encoder.
// No dependencies; every other design file imports this package.
package sre_pkg;

   // Field widths
   localparam int CODE_W = 6;
   localparam int LEN_W  = 13;
   localparam int THR_W  = 5;
   localparam int CNT_W  = 5;
   localparam int IDX_W  = 4;

   // Defaults for top-level parameters
   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Commands carried on req_tuser
   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_REPEAT_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_INVERT_PIXELS    = 2'd1;
   localparam logic [1:0] CSR_TERMINAL_MODE    = 2'd2;

   // Characters
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SIXEL = 8'h3F;

   // Fixed byte sequences, addressed as [first, last] ranges
   localparam logic [IDX_W-1:0] SEQ_CLEAR_FIRST    = 4'd0;
   localparam logic [IDX_W-1:0] SEQ_START_FIRST    = 4'd6;
   localparam logic [IDX_W-1:0] SEQ_START_LAST     = 4'd9;
   localparam logic [IDX_W-1:0] SEQ_END_FIRST      = 4'd10;
   localparam logic [IDX_W-1:0] SEQ_END_LAST_PLAIN = 4'd11;
   localparam logic [IDX_W-1:0] SEQ_END_LAST_TERM  = 4'd14;
   localparam logic [IDX_W-1:0] SEQ_DASH           = 4'd15;

   localparam logic [7:0] SEQ_ROM [16] = '{
      8'h1B, 8'h5B, 8'h48,          // ESC [ H
      8'h1B, 8'h5B, 8'h4A,          // ESC [ J
      8'h1B, 8'h50, 8'h37, 8'h71,   // ESC P 7 q
      8'h1B, 8'h5C,                 // ESC backslash
      8'h1B, 8'h5B, 8'h48,          // ESC [ H
      8'h2D                         // band separator
   };

   typedef struct packed {
      logic [THR_W-1:0] repeat_threshold;
      logic             invert_pixels;
      logic             terminal_mode;
   } cfg_type;

   // One run to send, already classified
   typedef struct packed {
      logic              en;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      logic              rep;    // use the '!' count form
      logic [1:0]        place;  // decimal place of the leading digit
   } run_type;

   // Everything one input transaction sends, in order r1, r2, sequence
   typedef struct packed {
      run_type          r1;
      run_type          r2;
      logic             seq_en;
      logic [IDX_W-1:0] seq_first;
      logic [IDX_W-1:0] seq_last;
   } job_type;

   typedef struct packed {
      logic [3:0]       digit;
      logic [LEN_W-1:0] sub;
   } digit_type;

   function automatic run_type make_run(input logic [CODE_W-1:0] code,
                                        input logic [LEN_W-1:0]  len,
                                        input logic [THR_W-1:0]  thr);
      run_type r;
      r.en    = (len != '0);
      r.code  = code;
      r.len   = len;
      r.rep   = (len > LEN_W'(thr));
      if (len >= LEN_W'(1000))     r.place = 2'd3;
      else if (len >= LEN_W'(100)) r.place = 2'd2;
      else if (len >= LEN_W'(10))  r.place = 2'd1;
      else                         r.place = 2'd0;
      return r;
   endfunction

   // Threshold k * 10^place, one constant per arm
   function automatic logic [LEN_W:0] dec_step(input logic [1:0] place, input int k);
      logic [LEN_W:0] v;
      unique case (place)
         2'd0:    v = (LEN_W+1)'(k);
         2'd1:    v = (LEN_W+1)'(k * 10);
         2'd2:    v = (LEN_W+1)'(k * 100);
         default: v = (LEN_W+1)'(k * 1000);
      endcase
      return v;
   endfunction

   // Decimal digit at one place, with the amount to take off the value
   function automatic digit_type dec_digit(input logic [LEN_W-1:0] rem,
                                           input logic [1:0]       place);
      digit_type d;
      logic [LEN_W:0] th;
      d.digit = 4'd0;
      d.sub   = '0;
      for (int k = 1; k < 10; k++) begin
         th = dec_step(place, k);
         if ({1'b0, rem} >= th) begin
            d.digit = 4'(k);
            d.sub   = th[LEN_W-1:0];
         end
      end
      return d;
   endfunction

   function automatic logic [7:0] sixel_char(input logic [CODE_W-1:0] code);
      return 8'({2'b00, code}) + CH_SIXEL;
   endfunction

endpackage

// ===== design/sixel_run_length_encoder_core.sv =====
// Top level of the sixel run-length encoder: configuration registers, front end,
// job queue and back end. Depends on sre_pkg, sre_front, sre_queue, sre_back.
//
// Channel   Direction  Signals                                  Contents
// req       in         req_tvalid/tready/tdata/tlast/tuser      column, band end, command
// rsp       out        rsp_tvalid/tready/tdata/tlast            output byte, last of item
// csr       in         csr_we/addr/wdata                        register writes
//
// An input transaction is taken every cycle while the job queue has room.
// The back end takes a job in its idle state, emitting nothing, then sends its output bytes;
// it takes no new job from the queue until the last byte of the current job is emitted.
// Synchronous active-high reset; no clearing pass.
// A stalled rsp channel holds the output register; the queue absorbs QUEUE_DEPTH jobs.
module sixel_run_length_encoder_core #(
   parameter int MAX_WIDTH   = sre_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = sre_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [5:0] column_bits, [7:6] zero
   input  logic       req_tlast,   // band_end
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last_of_run
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [4:0] csr_wdata
);
   import sre_pkg::*;

   cfg_type cfg_ff;
   logic    q_full, q_valid, q_pop, push_valid;
   job_type push_job, q_head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_threshold <= THR_W'(3);
         cfg_ff.invert_pixels    <= 1'b1;
         cfg_ff.terminal_mode    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_REPEAT_THRESHOLD: cfg_ff.repeat_threshold <= csr_wdata;
            CSR_INVERT_PIXELS:    cfg_ff.invert_pixels    <= csr_wdata[0];
            CSR_TERMINAL_MODE:    cfg_ff.terminal_mode    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   sre_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   sre_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   sre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/sre_front.sv =====
// Front end: accepts input transactions, tracks the open run and classifies
// each transaction into at most one job for the queue. Depends on sre_pkg.
module sre_front #(
   parameter int MAX_WIDTH = sre_pkg::MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  sre_pkg::cfg_type cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [5:0] column_bits, [7:6] zero
   input  logic             req_tlast,   // band_end
   input  logic [1:0]       req_tuser,   // [1:0] command
   input  logic             q_full,
   output logic             push_valid,
   output sre_pkg::job_type push_job
);
   import sre_pkg::*;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WIDTH);

   logic [CODE_W-1:0] run_code_ff, run_code_in;
   logic [LEN_W-1:0]  run_len_ff, run_len_in;
   logic              accept;
   logic [CODE_W-1:0] code;
   logic [LEN_W-1:0]  new_len;
   job_type           job;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;

   // Classify the transaction and compute the next run state
   always_comb begin
      code        = cfg.invert_pixels ? (req_tdata[5:0] ^ 6'h3F) : req_tdata[5:0];
      job         = '0;
      new_len     = run_len_ff;
      run_code_in = run_code_ff;
      run_len_in  = run_len_ff;
      unique case (req_tuser)
         CMD_PIXEL: begin
            if (code != run_code_ff) begin
               job.r1  = make_run(run_code_ff, run_len_ff, cfg.repeat_threshold);
               new_len = LEN_W'(1);
            end else if (run_len_ff < LEN_MAX) begin
               new_len = run_len_ff + LEN_W'(1);
            end
            if (req_tlast) begin
               job.r2        = make_run(code, new_len, cfg.repeat_threshold);
               job.r2.en     = (code != '0);
               job.seq_en    = 1'b1;
               job.seq_first = SEQ_DASH;
               job.seq_last  = SEQ_DASH;
               run_code_in   = '0;
               run_len_in    = '0;
            end else begin
               run_code_in = code;
               run_len_in  = new_len;
            end
         end
         CMD_START: begin
            job.seq_en    = 1'b1;
            job.seq_first = cfg.terminal_mode ? SEQ_CLEAR_FIRST : SEQ_START_FIRST;
            job.seq_last  = SEQ_START_LAST;
            run_code_in   = '0;
            run_len_in    = '0;
         end
         CMD_END: begin
            job.seq_en    = 1'b1;
            job.seq_first = SEQ_END_FIRST;
            job.seq_last  = cfg.terminal_mode ? SEQ_END_LAST_TERM : SEQ_END_LAST_PLAIN;
            run_code_in   = '0;
            run_len_in    = '0;
         end
         CMD_NOP: begin
         end
         default: begin
         end
      endcase
   end

   assign push_valid = accept & (job.r1.en | job.r2.en | job.seq_en);
   assign push_job   = job;

   // Open run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_code_ff <= '0;
         run_len_ff  <= '0;
      end else if (accept) begin
         run_code_ff <= run_code_in;
         run_len_ff  <= run_len_in;
      end
   end

endmodule

// ===== design/sre_queue.sv =====
// Short job queue between front and back end, a small register FIFO.
// Depends on sre_pkg for the job type.
module sre_queue #(
   parameter int DEPTH = sre_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sre_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output sre_pkg::job_type head_job
);
   import sre_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push & ~do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop & ~do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== design/sre_back.sv =====
// Back end: expands queued jobs into output bytes, one byte per cycle within a job while
// rsp is not stalled, through a registered output stage. Depends on sre_pkg.
module sre_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  sre_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_char
   output logic             rsp_tlast    // last_of_run
);
   import sre_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BANG  = 3'd1;
   localparam logic [2:0] ST_DIGIT = 3'd2;
   localparam logic [2:0] ST_CHAR  = 3'd3;
   localparam logic [2:0] ST_SEQ   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [1:0]        place_ff, place_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              has_r2_ff, has_r2_in;
   run_type           r2_ff, r2_in;
   logic              seq_en_ff, seq_en_in;
   logic [IDX_W-1:0]  seq_idx_ff, seq_idx_in;
   logic [IDX_W-1:0]  seq_last_ff, seq_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              emit;
   logic [7:0]        emit_byte;
   logic              emit_last;
   logic              do_load;
   run_type           load_run;
   digit_type         dig;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign dig      = dec_digit(rem_ff, place_ff);

   // Byte sequencer
   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      rem_in      = rem_ff;
      place_in    = place_ff;
      cnt_in      = cnt_ff;
      has_r2_in   = has_r2_ff;
      r2_in       = r2_ff;
      seq_en_in   = seq_en_ff;
      seq_idx_in  = seq_idx_ff;
      seq_last_in = seq_last_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      emit_byte   = 8'h00;
      emit_last   = 1'b0;
      do_load     = 1'b0;
      load_run    = r2_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               r2_in       = q_head.r2;
               seq_en_in   = q_head.seq_en;
               seq_idx_in  = q_head.seq_first;
               seq_last_in = q_head.seq_last;
               if (q_head.r1.en) begin
                  do_load   = 1'b1;
                  load_run  = q_head.r1;
                  has_r2_in = q_head.r2.en;
               end else if (q_head.r2.en) begin
                  do_load   = 1'b1;
                  load_run  = q_head.r2;
                  has_r2_in = 1'b0;
               end else begin
                  has_r2_in = 1'b0;
                  state_in  = ST_SEQ;
               end
            end
         end
         ST_BANG: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CH_BANG;
               state_in  = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CH_ZERO + 8'(dig.digit);
               rem_in    = rem_ff - dig.sub;
               if (place_ff == 2'd0) begin
                  state_in = ST_CHAR;
                  cnt_in   = CNT_W'(1);
               end else begin
                  place_in = place_ff - 2'd1;
               end
            end
         end
         ST_CHAR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = sixel_char(code_ff);
               if (cnt_ff == CNT_W'(1)) begin
                  // run finished: next run, then sequence, else done
                  if (has_r2_ff) begin
                     do_load   = 1'b1;
                     has_r2_in = 1'b0;
                  end else if (seq_en_ff) begin
                     state_in = ST_SEQ;
                  end else begin
                     state_in  = ST_IDLE;
                     emit_last = 1'b1;
                  end
               end else begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         ST_SEQ: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = SEQ_ROM[seq_idx_ff];
               if (seq_idx_ff == seq_last_ff) begin
                  state_in  = ST_IDLE;
                  emit_last = 1'b1;
               end else begin
                  seq_idx_in = seq_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Start a run: count form or repeated characters
      if (do_load) begin
         code_in  = load_run.code;
         rem_in   = load_run.len;
         place_in = load_run.place;
         cnt_in   = load_run.rep ? CNT_W'(1) : load_run.len[CNT_W-1:0];
         state_in = load_run.rep ? ST_BANG : ST_CHAR;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         has_r2_ff    <= 1'b0;
         seq_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         has_r2_ff    <= has_r2_in;
         seq_en_ff    <= seq_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rem_ff      <= rem_in;
      place_ff    <= place_in;
      cnt_ff      <= cnt_in;
      r2_ff       <= r2_in;
      seq_idx_ff  <= seq_idx_in;
      seq_last_ff <= seq_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/sre_checker.sv =====
// Port-level checker for the sixel run-length encoder, bound to the top level.
// Depends on sre_pkg and sixel_run_length_encoder_core.
module sre_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import sre_pkg::*;

   // A stalled output byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // Reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // The band separator always closes its item
   a_dash_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CH_DASH |-> rsp_tlast)
      else $error("band separator not marked last");

   // A repeat introducer never ends its item, since its count follows
   a_bang_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CH_BANG |-> !rsp_tlast)
      else $error("repeat introducer marked last");

   // Escape sequences never end on ESC
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CH_ESC |-> !rsp_tlast)
      else $error("escape byte marked last");

endmodule

bind sixel_run_length_encoder_core sre_checker u_sre_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
